// ===== src/lpma_pkg.sv =====
// shared types, widths and codes of the link power mode advisor
package lpma_pkg;

  // table geometry
  localparam int MaxDevices = 8;
  localparam int IdxW       = $clog2(MaxDevices);
  localparam int CntW       = $clog2(MaxDevices + 1);

  // field widths
  localparam int AddrW = 48;
  localparam int ByteW = 32;
  localparam int TickW = 8;
  localparam int SumW  = ByteW + 2;

  // stream payload widths, padded to whole bytes
  localparam int InDataW  = AddrW + 2 * ByteW;
  localparam int OutDataW = ((AddrW + 1 + 7) / 8) * 8;

  // register reset values
  localparam logic [TickW-1:0] TicksRst   = 8'd4;
  localparam logic [ByteW-1:0] SniffRst   = 32'd1000;
  localparam logic [ByteW-1:0] UnsniffRst = 32'd1000;

  // input item kinds
  typedef enum logic [1:0] {
    RqReport = 2'd0,
    RqAdd    = 2'd1,
    RqRemove = 2'd2
  } req_type_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgTicks   = 2'd0,
    CfgSniff   = 2'd1,
    CfgUnsniff = 2'd2,
    CfgLink    = 2'd3
  } cfg_idx_e;

  // one table entry
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] total;
    logic [TickW-1:0] tick;
  } entry_t;

  // result of the shared add and compare unit
  typedef struct packed {
    logic [ByteW:0]   sum;
    logic [ByteW-1:0] sat;
    logic             lt;
  } calc_res_t;

endpackage

// ===== src/lpma_calc.sv =====
// shared adder with saturation and one magnitude comparator
module lpma_calc (
  input  logic                     acc_mode_i,
  input  logic [lpma_pkg::ByteW:0] op_a_i,
  input  logic [lpma_pkg::ByteW:0] op_b_i,
  input  logic [lpma_pkg::ByteW-1:0] cmp_ref_i,
  output lpma_pkg::calc_res_t      res_o
);
  import lpma_pkg::*;

  logic [SumW-1:0]  sum;
  logic [ByteW-1:0] sat;
  logic [SumW-1:0]  cmp_x;
  logic [SumW-1:0]  cmp_y;

  // wide add, saturated to the accumulator width
  assign sum = {1'b0, op_a_i} + {1'b0, op_b_i};
  assign sat = (|sum[SumW-1:ByteW]) ? '1 : sum[ByteW-1:0];

  // accumulate: saturated total below reference; sum phase: reference below sum
  assign cmp_x = acc_mode_i ? {2'b00, sat} : {2'b00, cmp_ref_i};
  assign cmp_y = acc_mode_i ? {2'b00, cmp_ref_i} : sum;

  assign res_o.sum = sum[ByteW:0];
  assign res_o.sat = sat;
  assign res_o.lt  = cmp_x < cmp_y;

endmodule

// ===== src/link_power_mode_advisor.sv =====
// link power mode advisor: entry table, walk sequencer and result stream
// sequence: add and ignored items pass through setup and return to idle; remove reads
// each of the at most 8 stored entries and compacts the survivors; report reads each stored
// entry, may emit requests for a matching one and closes the run in a finish step; a report
// waits while a held request meets a stalled output word
// throughput: one word at a time; the entry table has one read port, so each entry visited
// takes a read step before its compare step, and tready stays low until the item is done
// reset: registers return to their defaults, the table is empty, stored entries are not cleared
module link_power_mode_advisor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  lpma_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [lpma_pkg::ByteW-1:0]      cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lpma_pkg::InDataW-1:0]    s_axis_tdata_i,  // dev_addr, bytes_sent, bytes_received
  input  logic [1:0]                      s_axis_tuser_i,  // req_type
  // output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lpma_pkg::OutDataW-1:0]   m_axis_tdata_o,  // mode_request, target_addr, zero pad
  output logic                            m_axis_tlast_o
);
  import lpma_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StRead,
    StCalc,
    StEmitDec,
    StEmitUns,
    StFinish
  } state_e;

  // sequencer state
  state_e           state_q, state_d;
  req_type_e        type_q, type_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] sent_q, sent_d;
  logic [ByteW-1:0] recv_q, recv_d;
  logic [ByteW:0]   sum_q, sum_d;
  logic             big_q, big_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  keep_q, keep_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             dec_v_q, dec_v_d;
  logic             dec_mode_q, dec_mode_d;
  logic             uns_v_q, uns_v_d;
  logic             pend_v_q, pend_v_d;
  logic             pend_mode_q, pend_mode_d;

  // configuration registers
  logic [TickW-1:0] ticks_q, ticks_d;
  logic [ByteW-1:0] sniff_q, sniff_d;
  logic [ByteW-1:0] unsniff_q, unsniff_d;
  logic             link_q, link_d;

  // output register
  logic             m_valid_q, m_valid_d;
  logic             m_mode_q, m_mode_d;
  logic [AddrW-1:0] m_addr_q, m_addr_d;
  logic             m_last_q, m_last_d;

  // entry table
  entry_t           entry_mem_q [MaxDevices];
  entry_t           rd_q;
  logic             rd_en;
  logic             mem_we;
  logic [IdxW-1:0]  mem_wa;
  entry_t           mem_wd;

  // shared unit
  logic             acc_mode;
  calc_res_t        calc_res;

  logic             out_free;
  logic             last_ent;
  logic             addr_match;
  logic [TickW-1:0] tick_inc;
  logic             fire;

  lpma_calc u_calc (
    .acc_mode_i (acc_mode),
    .op_a_i     (acc_mode ? {1'b0, rd_q.total} : {1'b0, sent_q}),
    .op_b_i     (acc_mode ? sum_q : {1'b0, recv_q}),
    .cmp_ref_i  (acc_mode ? sniff_q : unsniff_q),
    .res_o      (calc_res)
  );

  assign acc_mode   = (state_q == StCalc);
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign last_ent   = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign addr_match = (rd_q.addr == addr_q);
  assign tick_inc   = rd_q.tick + TickW'(1);
  assign fire       = (tick_inc == ticks_q);

  // next state of sequencer, configuration and output register
  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    addr_d      = addr_q;
    sent_d      = sent_q;
    recv_d      = recv_q;
    sum_d       = sum_q;
    big_d       = big_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    count_d     = count_q;
    dec_v_d     = dec_v_q;
    dec_mode_d  = dec_mode_q;
    uns_v_d     = uns_v_q;
    pend_v_d    = pend_v_q;
    pend_mode_d = pend_mode_q;
    ticks_d     = ticks_q;
    sniff_d     = sniff_q;
    unsniff_d   = unsniff_q;
    link_d      = link_q;
    m_valid_d   = m_valid_q;
    m_mode_d    = m_mode_q;
    m_addr_d    = m_addr_q;
    m_last_d    = m_last_q;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = rd_q;

    // output word taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    // register writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTicks:   ticks_d   = cfg_data_i[TickW-1:0];
        CfgSniff:   sniff_d   = cfg_data_i;
        CfgUnsniff: unsniff_d = cfg_data_i;
        CfgLink:    link_d    = cfg_data_i[0];
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          type_d  = req_type_e'(s_axis_tuser_i);
          addr_d  = s_axis_tdata_i[AddrW-1:0];
          sent_d  = s_axis_tdata_i[AddrW +: ByteW];
          recv_d  = s_axis_tdata_i[AddrW+ByteW +: ByteW];
          idx_d   = '0;
          keep_d  = '0;
          state_d = StSetup;
        end
      end

      StSetup: begin
        case (type_q)
          RqReport: begin
            sum_d   = calc_res.sum;
            big_d   = calc_res.lt && link_q;
            state_d = (count_q != '0) ? StRead : StFinish;
          end
          RqAdd: begin
            // a full table drops the add
            if (count_q < CntW'(MaxDevices)) begin
              mem_we      = 1'b1;
              mem_wa      = count_q[IdxW-1:0];
              mem_wd.addr  = addr_q;
              mem_wd.total = '0;
              mem_wd.tick  = '0;
              count_d     = count_q + CntW'(1);
            end
            state_d = StIdle;
          end
          RqRemove: begin
            state_d = (count_q != '0) ? StRead : StIdle;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end

      StRead: begin
        rd_en   = 1'b1;
        state_d = StCalc;
      end

      StCalc: begin
        if (type_q == RqRemove) begin
          // compact: copy survivors down to the keep index
          if (!addr_match) begin
            mem_we = 1'b1;
            mem_wa = keep_q[IdxW-1:0];
            keep_d = keep_q + CntW'(1);
          end
          if (last_ent) begin
            count_d = keep_q + CntW'(!addr_match);
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = StRead;
          end
        end else if (addr_match) begin
          // accumulate, count the tick and decide at the period
          mem_we       = 1'b1;
          mem_wd.total = (fire && link_q) ? '0 : calc_res.sat;
          mem_wd.tick  = fire ? '0 : tick_inc;
          dec_v_d      = fire && link_q;
          dec_mode_d   = !calc_res.lt;
          uns_v_d      = big_q;
          state_d      = StEmitDec;
        end else if (last_ent) begin
          state_d = StFinish;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = StRead;
        end
      end

      StEmitDec: begin
        // the held request moves out once a newer one exists
        if (!dec_v_q) begin
          state_d = StEmitUns;
        end else if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            m_valid_d = 1'b1;
            m_mode_d  = pend_mode_q;
            m_addr_d  = addr_q;
            m_last_d  = 1'b0;
          end
          pend_v_d    = 1'b1;
          pend_mode_d = dec_mode_q;
          state_d     = StEmitUns;
        end
      end

      StEmitUns: begin
        if (!uns_v_q || !pend_v_q || out_free) begin
          if (uns_v_q) begin
            if (pend_v_q) begin
              m_valid_d = 1'b1;
              m_mode_d  = pend_mode_q;
              m_addr_d  = addr_q;
              m_last_d  = 1'b0;
            end
            pend_v_d    = 1'b1;
            pend_mode_d = 1'b1;
          end
          if (last_ent) begin
            state_d = StFinish;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = StRead;
          end
        end
      end

      StFinish: begin
        // the held request closes the run
        if (!pend_v_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_mode_d  = pend_mode_q;
          m_addr_d  = addr_q;
          m_last_d  = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      type_q      <= RqReport;
      addr_q      <= '0;
      sent_q      <= '0;
      recv_q      <= '0;
      sum_q       <= '0;
      big_q       <= 1'b0;
      idx_q       <= '0;
      keep_q      <= '0;
      count_q     <= '0;
      dec_v_q     <= 1'b0;
      dec_mode_q  <= 1'b0;
      uns_v_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      pend_mode_q <= 1'b0;
      ticks_q     <= TicksRst;
      sniff_q     <= SniffRst;
      unsniff_q   <= UnsniffRst;
      link_q      <= 1'b0;
      m_valid_q   <= 1'b0;
      m_mode_q    <= 1'b0;
      m_addr_q    <= '0;
      m_last_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      addr_q      <= addr_d;
      sent_q      <= sent_d;
      recv_q      <= recv_d;
      sum_q       <= sum_d;
      big_q       <= big_d;
      idx_q       <= idx_d;
      keep_q      <= keep_d;
      count_q     <= count_d;
      dec_v_q     <= dec_v_d;
      dec_mode_q  <= dec_mode_d;
      uns_v_q     <= uns_v_d;
      pend_v_q    <= pend_v_d;
      pend_mode_q <= pend_mode_d;
      ticks_q     <= ticks_d;
      sniff_q     <= sniff_d;
      unsniff_q   <= unsniff_d;
      link_q      <= link_d;
      m_valid_q   <= m_valid_d;
      m_mode_q    <= m_mode_d;
      m_addr_q    <= m_addr_d;
      m_last_q    <= m_last_d;
    end
  end

  // entry table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= entry_mem_q[idx_q];
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - AddrW - 1){1'b0}}, m_addr_q, m_mode_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== src/lpma_checker.sv =====
// port-level checks of the link power mode advisor and their binding
module lpma_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_o,
  input  logic [lpma_pkg::InDataW-1:0]    s_axis_tdata_i,  // dev_addr, bytes_sent, bytes_received
  input  logic [1:0]                      s_axis_tuser_i,  // req_type
  input  logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic [lpma_pkg::OutDataW-1:0]   m_axis_tdata_o,  // mode_request, target_addr, zero pad
  input  logic                            m_axis_tlast_o
);
  import lpma_pkg::*;

  logic             s_acc;
  logic [AddrW-1:0] item_addr_q;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // address of the item in progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_addr_q <= '0;
    end else if (s_acc) begin
      item_addr_q <= s_axis_tdata_i[AddrW-1:0];
    end
  end

  // one item at a time: no word taken right after an accepted one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken while an item is in progress");

  // adds, removes and unused kinds never produce a request
  a_quiet_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i != RqReport) && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("request produced by a non-report item");

  // a new request names the device of the item in progress
  a_target_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> (m_axis_tdata_o[AddrW:1] == item_addr_q))
    else $error("request for a device other than the reported one");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

endmodule

bind link_power_mode_advisor lpma_checker u_lpma_checker (.*);
